### rtl/core/cfl_timestep_min_macros.svh
// Assertion macros shared by the timestep-minimum RTL.
`ifndef CFL_TIMESTEP_MIN_MACROS_SVH
`define CFL_TIMESTEP_MIN_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cfl_pkg.sv
// Shared types, constants and helpers of the timestep-minimum block.
package cfl_pkg;

  localparam int FracBits  = 16;
  localparam int DataW     = 32;
  localparam int ResW      = 31;
  localparam int NumW      = 49;
  localparam int DenW      = 32;
  localparam int SqrtW     = 48;
  localparam int SqrtSteps = SqrtW / 2;
  localparam int MulAW     = 33;
  localparam int MulBW     = 32;
  localparam int ProdW     = MulAW + MulBW;
  localparam int CntW      = 5;

  localparam logic [ResW-1:0] MaxRes = '1;

  localparam logic [17:0] GammaRst   = 18'd91750;
  localparam logic [30:0] DxRst      = 31'd6554;
  localparam logic [16:0] CourantRst = 17'd32768;
  localparam logic [17:0] GammaOne   = 18'(1 << FracBits);

  typedef enum logic [1:0] {
    REG_GAMMA   = 2'd0,
    REG_DX      = 2'd1,
    REG_COURANT = 2'd2
  } cfl_reg_e;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } cfl_op_e;

  typedef struct packed {
    logic            start;
    cfl_op_e         op;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } cfl_unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cfl_unit_stat_t;

  // Magnitude of a two's complement word, as an unsigned word.
  function automatic logic [DataW-1:0] mag32(logic [DataW-1:0] x);
    logic [DataW-1:0] r;
    r = x[DataW-1] ? (~x + DataW'(1)) : x;
    return r;
  endfunction

endpackage

### rtl/core/cfl_if.sv
// Handshake channels: one cell item in, one timestep result out.
interface cfl_cell_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] density;
  logic signed [31:0] momentum_x;
  logic signed [31:0] momentum_y;
  logic signed [31:0] momentum_z;
  logic signed [31:0] total_energy;
  logic               last_cell;

  modport source (output valid, density, momentum_x, momentum_y, momentum_z,
                  total_energy, last_cell, input ready);
  modport sink (input valid, density, momentum_x, momentum_y, momentum_z,
                total_energy, last_cell, output ready);
endinterface

interface cfl_result_if;
  logic        valid;
  logic        ready;
  logic [30:0] min_timestep;

  modport source (output valid, min_timestep, input ready);
  modport sink (input valid, min_timestep, output ready);
endinterface

### rtl/core/cfl_timestep_min.sv
// Top level: CFL timestep per cell and running minimum over a sweep.
//
// Usage:
//   cell_in : sink channel, one conserved cell state per item (density,
//             three momenta, total energy, last_cell flag).
//   result  : source channel, one min_timestep item per sweep, sent when
//             the item flagged last_cell has been worked through.
//   cfg     : write port, cfg_we_i with cfg_idx_i 0 gamma, 1 dx, 2 Courant.
// Each item runs in order through three velocity divisions, the multiply
// and pressure steps, the sound-speed division, the 24-step square root,
// and the timestep division with the minimum update; only then does the
// block return to idle and accept the next item. A division whose
// quotient saturates skips the shift-subtract steps. cell_in.ready is
// high only between items.
// The result sits in an output register; while the receiver stalls, the
// block still takes the next item and stops only if another sweep ends
// before the earlier result is taken.
// Reset loads the register defaults and sets the running minimum to the
// maximum code; no result is pending.
`include "cfl_timestep_min_macros.svh"

module cfl_timestep_min (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  cfl_cell_if.sink    cell_in,
  cfl_result_if.source result
);

  typedef enum logic [3:0] {
    S_IDLE, S_VSTART, S_VWAIT, S_VSQ, S_VACC, S_KE_MUL, S_KE,
    S_EINT, S_P_MUL, S_P, S_R_MUL, S_R_START, S_R_WAIT,
    S_CS_START, S_CS_WAIT, S_DT_MUL
  } state_e;

  typedef enum logic [1:0] {
    T_NONE, T_DT_START, T_DT_WAIT, T_FIN
  } tail_e;

  state_e state_q;
  tail_e  tail_q;

  logic [17:0]              gamma_q;
  logic [30:0]              dx_q;
  logic [16:0]              courant_q;

  logic [30:0]              d_q;
  logic [31:0]              mom_q [3];
  logic signed [31:0]       energy_q;
  logic                     last_q;
  logic [1:0]               idx_q;
  logic [30:0]              v_q;
  logic [30:0]              vmax_q;
  logic [63:0]              vsq_q;
  logic [30:0]              ke_q;
  logic [32:0]              emag_q;
  logic                     eneg_q;
  logic [30:0]              p_q;
  logic [30:0]              r_q;
  logic [30:0]              cs_q;
  logic [30:0]              dt_q;
  logic [30:0]              min_q;
  logic [cfl_pkg::ProdW-1:0] prod_q;
  logic                     res_valid_q;
  logic [30:0]              res_q;

  logic [cfl_pkg::MulAW-1:0] mul_a;
  logic [cfl_pkg::MulBW-1:0] mul_b;
  logic [31:0]              s_val;
  logic [17:0]              gm1_mag;
  logic                     gm1_neg;
  logic [33:0]              eint;
  logic [30:0]              new_min;
  logic                     res_load;
  logic [50:0]              p_prod;
  logic [34:0]              p_shift;

  cfl_pkg::cfl_unit_req_t   unit_req;
  cfl_pkg::cfl_unit_stat_t  unit_stat;
  logic [30:0]              unit_res;

  cfl_iter_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (unit_req),
    .stat_o   (unit_stat),
    .result_o (unit_res)
  );

  // Derived terms
  assign s_val   = (|vsq_q[63:48]) ? '1 : vsq_q[47:16];
  assign gm1_neg = gamma_q < cfl_pkg::GammaOne;
  assign gm1_mag = gm1_neg ? (cfl_pkg::GammaOne - gamma_q) : (gamma_q - cfl_pkg::GammaOne);
  assign eint    = 34'(signed'(energy_q)) - 34'(ke_q);
  assign new_min = (dt_q < min_q) ? dt_q : min_q;
  assign res_load = (tail_q == T_FIN) && last_q && (!res_valid_q || result.ready);
  assign p_prod  = prod_q[50:0];
  assign p_shift = p_prod[50:cfl_pkg::FracBits];

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_VSQ: begin
        mul_a = cfl_pkg::MulAW'(v_q);
        mul_b = cfl_pkg::MulBW'(v_q);
      end
      S_KE_MUL: begin
        mul_a = cfl_pkg::MulAW'(d_q);
        mul_b = s_val;
      end
      S_P_MUL: begin
        mul_a = emag_q;
        mul_b = cfl_pkg::MulBW'(gm1_mag);
      end
      S_R_MUL: begin
        mul_a = cfl_pkg::MulAW'(gamma_q);
        mul_b = cfl_pkg::MulBW'(p_q);
      end
      S_DT_MUL: begin
        mul_a = cfl_pkg::MulAW'(courant_q);
        mul_b = cfl_pkg::MulBW'(dx_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Drive the shared unit
  always_comb begin
    unit_req.start = 1'b0;
    unit_req.op    = cfl_pkg::OP_DIV;
    unit_req.num   = '0;
    unit_req.den   = cfl_pkg::DenW'(d_q);
    if (tail_q == T_DT_START) begin
      unit_req.start = 1'b1;
      unit_req.num   = prod_q[cfl_pkg::NumW-1:0];
      unit_req.den   = cfl_pkg::DenW'(vmax_q) + cfl_pkg::DenW'(cs_q) + cfl_pkg::DenW'(1);
    end else begin
      case (state_q)
        S_VSTART: begin
          unit_req.start = 1'b1;
          unit_req.num   = cfl_pkg::NumW'(mom_q[idx_q]) << cfl_pkg::FracBits;
        end
        S_R_START: begin
          unit_req.start = 1'b1;
          unit_req.num   = prod_q[cfl_pkg::NumW-1:0];
        end
        S_CS_START: begin
          unit_req.start = 1'b1;
          unit_req.op    = cfl_pkg::OP_SQRT;
          unit_req.num   = cfl_pkg::NumW'(r_q) << cfl_pkg::FracBits;
        end
        default: begin
          unit_req.start = 1'b0;
        end
      endcase
    end
  end

  // Sequence one item and hold the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tail_q      <= T_NONE;
      gamma_q     <= cfl_pkg::GammaRst;
      dx_q        <= cfl_pkg::DxRst;
      courant_q   <= cfl_pkg::CourantRst;
      d_q         <= '0;
      mom_q       <= '{default: '0};
      energy_q    <= '0;
      last_q      <= 1'b0;
      idx_q       <= '0;
      v_q         <= '0;
      vmax_q      <= '0;
      vsq_q       <= '0;
      ke_q        <= '0;
      emag_q      <= '0;
      eneg_q      <= 1'b0;
      p_q         <= '0;
      r_q         <= '0;
      cs_q        <= '0;
      dt_q        <= '0;
      min_q       <= cfl_pkg::MaxRes;
      prod_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      prod_q <= mul_a * mul_b;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          cfl_pkg::REG_GAMMA:   gamma_q   <= cfg_data_i[17:0];
          cfl_pkg::REG_DX:      dx_q      <= cfg_data_i;
          cfl_pkg::REG_COURANT: courant_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end

      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (result.ready) begin
        res_valid_q <= 1'b0;
      end

      // Timestep division and minimum update
      case (tail_q)
        T_DT_START: tail_q <= T_DT_WAIT;
        T_DT_WAIT: begin
          if (unit_stat.done) begin
            dt_q   <= unit_res;
            tail_q <= T_FIN;
          end
        end
        T_FIN: begin
          if (!last_q) begin
            min_q   <= new_min;
            tail_q  <= T_NONE;
            state_q <= S_IDLE;
          end else if (res_load) begin
            res_q   <= new_min;
            min_q   <= cfl_pkg::MaxRes;
            tail_q  <= T_NONE;
            state_q <= S_IDLE;
          end
        end
        default: ;
      endcase

      case (state_q)
        S_IDLE: begin
          if (cell_in.valid) begin
            d_q <= (cell_in.density[31] || cell_in.density == '0) ?
                   31'd1 : cell_in.density[30:0];
            mom_q[0] <= cfl_pkg::mag32(cell_in.momentum_x);
            mom_q[1] <= cfl_pkg::mag32(cell_in.momentum_y);
            mom_q[2] <= cfl_pkg::mag32(cell_in.momentum_z);
            energy_q <= cell_in.total_energy;
            last_q   <= cell_in.last_cell;
            idx_q    <= '0;
            vmax_q   <= '0;
            vsq_q    <= '0;
            state_q  <= S_VSTART;
          end
        end
        S_VSTART: state_q <= S_VWAIT;
        S_VWAIT: begin
          if (unit_stat.done) begin
            v_q     <= unit_res;
            if (unit_res > vmax_q) vmax_q <= unit_res;
            state_q <= S_VSQ;
          end
        end
        S_VSQ: state_q <= S_VACC;
        S_VACC: begin
          vsq_q <= vsq_q + prod_q[63:0];
          if (idx_q == 2'd2) begin
            state_q <= S_KE_MUL;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_VSTART;
          end
        end
        S_KE_MUL: state_q <= S_KE;
        S_KE: begin
          ke_q    <= (|prod_q[64:48]) ? cfl_pkg::MaxRes : prod_q[47:17];
          state_q <= S_EINT;
        end
        S_EINT: begin
          eneg_q  <= eint[33];
          emag_q  <= eint[33] ? 33'(-eint) : eint[32:0];
          state_q <= S_P_MUL;
        end
        S_P_MUL: state_q <= S_P;
        S_P: begin
          // Floor pressure at one LSB, saturate at the maximum code
          if ((eneg_q ^ gm1_neg) || p_shift == '0) begin
            p_q <= 31'd1;
          end else if (|p_shift[34:31]) begin
            p_q <= cfl_pkg::MaxRes;
          end else begin
            p_q <= p_shift[30:0];
          end
          state_q <= S_R_MUL;
        end
        S_R_MUL: state_q <= S_R_START;
        S_R_START: state_q <= S_R_WAIT;
        S_R_WAIT: begin
          if (unit_stat.done) begin
            r_q     <= unit_res;
            state_q <= S_CS_START;
          end
        end
        S_CS_START: state_q <= S_CS_WAIT;
        S_CS_WAIT: begin
          if (unit_stat.done) begin
            cs_q    <= unit_res;
            state_q <= S_DT_MUL;
          end
        end
        S_DT_MUL: begin
          if (tail_q == T_NONE) tail_q <= T_DT_START;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cell_in.ready       = (state_q == S_IDLE);
  assign result.valid        = res_valid_q;
  assign result.min_timestep = res_q;

  `CFL_ASSERT_NEXT(a_busy_after_accept, cell_in.valid && cell_in.ready, !cell_in.ready, "ready after accept")
  `CFL_ASSERT_NOW(a_start_when_free, unit_req.start, !unit_stat.busy, "unit started while busy")
  `CFL_ASSERT_NOW(a_load_on_last, res_load, last_q && tail_q == T_FIN, "result without last cell")
  `CFL_ASSERT_NEXT(a_min_rearm, res_load, min_q == cfl_pkg::MaxRes && res_valid_q, "min not rearmed")

endmodule

### rtl/core/cfl_iter_unit.sv
// Shared shift-subtract unit: saturating divide and integer square root.
module cfl_iter_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfl_pkg::cfl_unit_req_t req_i,
  output cfl_pkg::cfl_unit_stat_t stat_o,
  output logic [cfl_pkg::ResW-1:0] result_o
);

  localparam int HiW = cfl_pkg::NumW - cfl_pkg::ResW;

  logic                          busy_q;
  logic                          done_q;
  cfl_pkg::cfl_op_e              op_q;
  logic [cfl_pkg::CntW-1:0]      cnt_q;
  logic [cfl_pkg::SqrtW-1:0]     acc_q;
  logic [cfl_pkg::SqrtW-1:0]     res_q;
  logic [cfl_pkg::SqrtW-1:0]     bit_q;

  logic [HiW-1:0]                num_hi;
  logic                          div_sat;
  logic [cfl_pkg::DenW:0]        rem2;
  logic                          div_ge;
  logic [cfl_pkg::DenW:0]        rem_sub;
  logic [cfl_pkg::SqrtW-1:0]     sq_t;
  logic                          sq_ge;

  // Saturation check and one step of each operation
  assign num_hi  = req_i.num[cfl_pkg::NumW-1:cfl_pkg::ResW];
  assign div_sat = cfl_pkg::DenW'(num_hi) >= req_i.den;
  assign rem2    = {acc_q[cfl_pkg::DenW-1:0], res_q[cfl_pkg::ResW-1]};
  assign div_ge  = rem2 >= {1'b0, bit_q[cfl_pkg::DenW-1:0]};
  assign rem_sub = rem2 - {1'b0, bit_q[cfl_pkg::DenW-1:0]};
  assign sq_t    = res_q + bit_q;
  assign sq_ge   = acc_q >= sq_t;

  // Run the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= cfl_pkg::OP_DIV;
      cnt_q  <= '0;
      acc_q  <= '0;
      res_q  <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q <= req_i.op;
        if (req_i.op == cfl_pkg::OP_SQRT) begin
          acc_q  <= req_i.num[cfl_pkg::SqrtW-1:0];
          res_q  <= '0;
          bit_q  <= cfl_pkg::SqrtW'(1) << (cfl_pkg::SqrtW - 2);
          cnt_q  <= cfl_pkg::CntW'(cfl_pkg::SqrtSteps);
          busy_q <= 1'b1;
        end else if (div_sat) begin
          res_q  <= cfl_pkg::SqrtW'(cfl_pkg::MaxRes);
          done_q <= 1'b1;
        end else begin
          acc_q  <= cfl_pkg::SqrtW'(num_hi);
          res_q  <= cfl_pkg::SqrtW'(req_i.num[cfl_pkg::ResW-1:0]);
          bit_q  <= cfl_pkg::SqrtW'(req_i.den);
          cnt_q  <= cfl_pkg::CntW'(cfl_pkg::ResW);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (op_q == cfl_pkg::OP_SQRT) begin
          if (sq_ge) begin
            acc_q <= acc_q - sq_t;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          acc_q <= div_ge ? cfl_pkg::SqrtW'(rem_sub) : cfl_pkg::SqrtW'(rem2);
          res_q <= {res_q[cfl_pkg::SqrtW-2:0], div_ge};
        end
        cnt_q <= cnt_q - cfl_pkg::CntW'(1);
        if (cnt_q == cfl_pkg::CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = res_q[cfl_pkg::ResW-1:0];

endmodule

### sim/cfl_timestep_min_test.sv
// Testbench for the CFL timestep-minimum block: predicted sweep minima against the DUT.
module cfl_timestep_min_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CyclesLimit = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [30:0] cfg_data_i;

  cfl_cell_if   cell_in();
  cfl_result_if result();

  cfl_timestep_min dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cell_in    (cell_in.sink),
    .result     (result.source)
  );

  typedef struct {
    logic [31:0] density;
    logic [31:0] mom_x;
    logic [31:0] mom_y;
    logic [31:0] mom_z;
    logic [31:0] energy;
    logic        last_cell;
  } cell_t;

  // Predictor state and configuration
  logic [17:0] gamma_q;
  logic [30:0] dx_q;
  logic [16:0] courant_q;
  logic [30:0] sweep_min;
  logic [30:0] expected_minima[$];

  int mismatches;
  int sweeps_seen;
  int cells_sent;
  int rx_wait;
  longint cycle_count;
  bit     hold_result;
  bit     rx_random;

  // Clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Abort on a runaway run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CyclesLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("cfl_timestep_min_test failed");
      $finish;
    end
  end

  function automatic logic [63:0] sat64(logic [63:0] v, logic [63:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs_word(logic [31:0] w);
    return w[31] ? (64'h1_0000_0000 - {32'd0, w}) : {32'd0, w};
  endfunction

  // Work out one cell's timestep
  function automatic logic [30:0] cell_timestep(cell_t c);
    logic [63:0] d, v, vmax, vsq, s, ke, p, r, cs, dt, m;
    longint      e, eint, gm1, prod;
    logic [31:0] moms[3];
    moms[0] = c.mom_x;
    moms[1] = c.mom_y;
    moms[2] = c.mom_z;
    d = (c.density[31] || c.density == 0) ? 64'd1 : {32'd0, c.density};
    vmax = 0;
    vsq = 0;
    for (int i = 0; i < 3; i++) begin
      m = abs_word(moms[i]);
      v = sat64((m << cfl_pkg::FracBits) / d, 64'h7FFF_FFFF);
      if (v > vmax) vmax = v;
      vsq = vsq + v * v;
    end
    s = sat64(vsq >> cfl_pkg::FracBits, 64'hFFFF_FFFF);
    ke = sat64((d * s) >> (cfl_pkg::FracBits + 1), 64'h7FFF_FFFF);
    e = longint'(signed'(c.energy));
    eint = e - longint'(ke);
    gm1 = longint'({46'd0, gamma_q}) - (64'sd1 <<< cfl_pkg::FracBits);
    prod = eint * gm1;
    if (prod <= 0) begin
      p = 1;
    end else begin
      p = sat64(64'(prod) >> cfl_pkg::FracBits, 64'h7FFF_FFFF);
      if (p < 1) p = 1;
    end
    r = sat64(({46'd0, gamma_q} * p) / d, 64'h7FFF_FFFF);
    cs = int_sqrt(r << cfl_pkg::FracBits);
    dt = sat64(({47'd0, courant_q} * {33'd0, dx_q}) / (vmax + cs + 1), 64'h7FFF_FFFF);
    return dt[30:0];
  endfunction

  // Advance the running minimum; queue the minimum on the last cell
  function automatic void predict_cell(cell_t c);
    logic [30:0] dt;
    dt = cell_timestep(c);
    if (dt < sweep_min) sweep_min = dt;
    if (c.last_cell) begin
      expected_minima.push_back(sweep_min);
      sweep_min = cfl_pkg::MaxRes;
    end
  endfunction

  // Send one item after a random gap; valid stays up until the next gap or drain
  task automatic send_cell(cell_t c, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      cell_in.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cell_in.valid        <= 1'b1;
    cell_in.density      <= c.density;
    cell_in.momentum_x   <= c.mom_x;
    cell_in.momentum_y   <= c.mom_y;
    cell_in.momentum_z   <= c.mom_z;
    cell_in.total_energy <= c.energy;
    cell_in.last_cell    <= c.last_cell;
    do @(posedge clk_i); while (!cell_in.ready);
    predict_cell(c);
    cells_sent++;
    @(negedge clk_i);
  endtask

  // Receiver ready: drawn wait per item or always high; held low in the pressure test
  always @(negedge clk_i) begin
    if (!rst_ni || hold_result) begin
      result.ready <= 1'b0;
    end else if (!rx_random) begin
      result.ready <= 1'b1;
    end else if (rx_wait > 0) begin
      result.ready <= 1'b0;
      if (result.valid) rx_wait--;
    end else begin
      result.ready <= 1'b1;
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    logic [30:0] want;
    if (rst_ni && result.valid && result.ready) begin
      sweeps_seen++;
      rx_wait = $urandom_range(0, 7);
      if (expected_minima.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", result.min_timestep);
      end else begin
        want = expected_minima.pop_front();
        if (result.min_timestep !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("min_timestep mismatch: expected %0d got %0d", want, result.min_timestep);
        end
      end
    end
  end

  // Drop valid, wait for all results, then let the block settle before a register write
  task automatic drain();
    cell_in.valid <= 1'b0;
    while (expected_minima.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_reg(cfl_pkg::cfl_reg_e idx, logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cfl_pkg::REG_GAMMA:   gamma_q   = val[17:0];
      cfl_pkg::REG_DX:      dx_q      = val;
      cfl_pkg::REG_COURANT: courant_q = val[16:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h0004_0000);
      4: return -$urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_t rand_cell(bit last);
    cell_t c;
    c.density = ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(1, 32'h0010_0000);
    c.mom_x = rand_word();
    c.mom_y = rand_word();
    c.mom_z = rand_word();
    c.energy = rand_word();
    c.last_cell = last;
    return c;
  endfunction

  function automatic cell_t make_cell(logic [31:0] d, logic [31:0] mx, logic [31:0] my,
                                      logic [31:0] mz, logic [31:0] e, bit last);
    cell_t c;
    c.density = d;
    c.mom_x = mx;
    c.mom_y = my;
    c.mom_z = mz;
    c.energy = e;
    c.last_cell = last;
    return c;
  endfunction

  // Directed corners: floors, extremes, nonpositive density
  task automatic test_corners();
    send_cell(make_cell(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b1));
    send_cell(make_cell(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    send_cell(make_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF,
                        1'b1));
    send_cell(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 1'b0));
    send_cell(make_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 1'b1));
    send_cell(make_cell(32'h0000_0001, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'hFFFF_FFFF, 1'b0));
    send_cell(make_cell(32'h0002_0000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                        32'h0010_0000, 1'b1));
    send_cell(make_cell(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b1));
    drain();
  endtask

  // Register extremes: gamma below and at limits, zero dx and Courant, max dx
  task automatic test_registers();
    write_reg(cfl_pkg::REG_GAMMA, 31'd0);
    send_cell(make_cell(32'h0001_0000, 32'h0000_1000, 32'h0, 32'h0, 32'h0010_0000, 1'b1));
    drain();
    write_reg(cfl_pkg::REG_GAMMA, 31'd196608);
    write_reg(cfl_pkg::REG_DX, 31'h7FFF_FFFF);
    write_reg(cfl_pkg::REG_COURANT, 31'd65536);
    for (int i = 0; i < 6; i++) send_cell(rand_cell((i % 2) == 1));
    drain();
    write_reg(cfl_pkg::REG_DX, 31'd0);
    send_cell(rand_cell(1'b1));
    drain();
    write_reg(cfl_pkg::REG_DX, 31'd6554);
    write_reg(cfl_pkg::REG_COURANT, 31'd0);
    send_cell(rand_cell(1'b1));
    drain();
    write_reg(cfl_pkg::REG_GAMMA, 31'h3FFFF);
    write_reg(cfl_pkg::REG_COURANT, 31'h1FFFF);
    write_reg(cfl_pkg::REG_DX, 31'd1);
    send_cell(rand_cell(1'b1));
    drain();
  endtask

  // Random sweeps of varied length under several settings
  task automatic test_random_sweeps(int n);
    int left;
    left = 0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) left = $urandom_range(1, 8);
      left--;
      send_cell(rand_cell(left == 0 || i == n - 1), (i / 40) % 3 != 0);
      if (i % 100 == 99) begin
        drain();
        write_reg(cfl_pkg::REG_GAMMA, 31'($urandom_range(65536, 196608)));
        write_reg(cfl_pkg::REG_DX, 31'($urandom_range(1, 32'h7FFF_FFFF)));
        write_reg(cfl_pkg::REG_COURANT, 31'($urandom_range(0, 65536)));
      end
    end
    drain();
  endtask

  // Hold the receiver off while sweeps keep ending, so the input stalls
  task automatic test_backpressure();
    fork
      begin
        hold_result = 1'b1;
        repeat (3000) @(negedge clk_i);
        hold_result = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_cell(rand_cell(1'b1), 1'b0);
    join
    drain();
  endtask

  initial begin
    cycle_count = 0;
    mismatches = 0;
    sweeps_seen = 0;
    cells_sent = 0;
    rx_wait = 0;
    hold_result = 1'b0;
    rx_random = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = cfl_pkg::REG_GAMMA;
    cfg_data_i = '0;
    cell_in.valid = 1'b0;
    cell_in.density = '0;
    cell_in.momentum_x = '0;
    cell_in.momentum_y = '0;
    cell_in.momentum_z = '0;
    cell_in.total_energy = '0;
    cell_in.last_cell = 1'b0;
    result.ready = 1'b0;
    gamma_q = cfl_pkg::GammaRst;
    dx_q = cfl_pkg::DxRst;
    courant_q = cfl_pkg::CourantRst;
    sweep_min = cfl_pkg::MaxRes;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corners();
    test_registers();
    test_backpressure();
    test_random_sweeps(200);
    rx_random = 1'b0;
    test_random_sweeps(230);

    $display("sent %0d cells, checked %0d sweep minima over several gamma/dx/Courant settings",
             cells_sent, sweeps_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_minima.size() == 0) begin
      $display("cfl_timestep_min_test passed");
    end else begin
      $display("cfl_timestep_min_test failed");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/cfl_pkg.sv
rtl/core/cfl_if.sv
rtl/core/cfl_iter_unit.sv
rtl/core/cfl_timestep_min.sv
sim/cfl_timestep_min_test.sv
